// ===== rtl/core/bpe_pkg.sv =====
// Shared constants and types for the Bezier point evaluator.
`timescale 1ns / 1ps

package bpe_pkg;

    // Default table depth and fraction width.
    localparam int P_MAX_POINTS = 16;
    localparam int P_FRAC_BITS  = 16;

    // Largest interpolation parameter, 2^31-1.
    localparam logic [30:0] T_MAX = '1;

    // Item operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_DURATION    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [4:0]  RST_POINT_COUNT = 5'd2;
    localparam logic [31:0] RST_DURATION    = 32'h0001_0000;

    // Evaluation sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD0,
        S_LD0,
        S_RDB,
        S_MUL,
        S_ACC
    } t_state;

endpackage

// ===== rtl/core/bpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bpe_div.sv =====
// Restoring divider that forms t = (time << FRAC_BITS) / duration, saturated.
`timescale 1ns / 1ps

module bpe_div #(
    parameter int FRAC_BITS = bpe_pkg::P_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_time,
    input  logic [31:0] i_dur,
    output logic        o_done,
    output logic [30:0] o_t
);

    localparam int NW   = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_num;
    logic [NW-1:0]   r_q;
    logic [31:0]     r_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic            r_zero;

    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_nx;

    // One quotient bit per cycle.
    always_comb begin
        rem_sh = {r_rem, r_num[NW-1]};
        ge     = (rem_sh >= {1'b0, i_dur});
        rem_nx = ge ? (rem_sh - {1'b0, i_dur}) : rem_sh;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_dur != 32'd0);
                r_done <= (i_dur == 32'd0);
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend, remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {i_time, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_q    <= '0;
            r_zero <= (i_dur == 32'd0);
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= rem_nx[31:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end

    // Saturate the quotient; a zero duration gives the maximum.
    always_comb begin
        if (r_zero || (r_q > NW'(bpe_pkg::T_MAX))) begin
            o_t = bpe_pkg::T_MAX;
        end else begin
            o_t = r_q[30:0];
        end
    end

    assign o_done = r_done;

endmodule

// ===== rtl/core/bpe_lerp.sv =====
// One coordinate lane of linear interpolation: a + floor((b - a) * t), saturated.
`timescale 1ns / 1ps

module bpe_lerp #(
    parameter int FRAC_BITS = bpe_pkg::P_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic        [30:0] i_t,
    output logic signed [31:0] o_p
);

    logic signed [32:0] diff;
    logic signed [31:0] t_s;
    logic signed [64:0] r_prod;
    logic signed [31:0] r_a;
    logic signed [64:0] scaled;
    logic signed [65:0] sum;

    assign diff = $signed({i_b[31], i_b}) - $signed({i_a[31], i_a});
    assign t_s  = $signed({1'b0, i_t});

    // Product register ahead of the add.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= 65'(diff * t_s);
            r_a    <= i_a;
        end
    end

    // Arithmetic shift floors toward minus infinity, then add and saturate.
    always_comb begin
        scaled = r_prod >>> FRAC_BITS;
        sum    = $signed({{34{r_a[31]}}, r_a}) + $signed({scaled[64], scaled});
        if ((&sum[65:31]) || !(|sum[65:31])) begin
            o_p = sum[31:0];
        end else if (sum[65]) begin
            o_p = 32'sh8000_0000;
        end else begin
            o_p = 32'sh7fff_ffff;
        end
    end

endmodule

// ===== rtl/core/bezier_point_evaluator.sv =====
// Top level of the Bezier point evaluator: register port, tables and sequencer.
`timescale 1ns / 1ps
// Usage:
// An item is taken when start is high and busy is low. A write item
// (operation 0) stores x, y and z at point_index and gives no
// result; a slot beyond the table is ignored. An evaluate item (operation 1)
// raises busy until the result is out.
// Evaluation first divides (time << FRAC_BITS) by duration in a bit-serial
// divider. It then runs de Casteljau rounds over a work RAM: each round
// fetches its first point, then runs its lerp steps (read, multiply, write
// back). The result strobe rises and busy falls at the same edge, so the
// next item can be taken while the result is shown.
// The result appears on o_pos_x/y/z for exactly one cycle with
// o_result_valid; the receiver cannot stall it, and the transfer completes
// at the edge ending that cycle. The user must write registers over the APB
// port only while busy is low; the block does not enforce it. Synchronous
// reset returns point_count to 2 and duration to 1.0; the point table holds
// garbage until written.
module bezier_point_evaluator #(
    parameter int MAX_POINTS = bpe_pkg::P_MAX_POINTS,
    parameter int FRAC_BITS  = bpe_pkg::P_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Command channel
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [3:0]         i_point_index,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_z_coord,
    input  logic [31:0]        i_time_value,
    // Result channel
    output logic               o_result_valid,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    bpe_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_len, n_len;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_first, n_first;
    logic [4:0]      r_point_count;
    logic [31:0]     r_duration;
    logic [95:0]     r_a;
    logic [95:0]     r_b;
    logic            r_valid;
    logic [31:0]     r_pos_x, r_pos_y, r_pos_z;

    logic          cfg_wr;
    logic          pt_we;
    logic          wk_we;
    logic [AW-1:0] raddr;
    logic [95:0]   pt_rdata, wk_rdata, rd_data, wk_wdata;
    logic          div_start, div_done;
    logic [30:0]   t_val;
    logic          a_load, lerp_load, done;
    logic [CW-1:0] len_clamp;
    logic [31:0]   p_x, p_y, p_z;

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= bpe_pkg::RST_POINT_COUNT;
            r_duration    <= bpe_pkg::RST_DURATION;
        end else if (cfg_wr) begin
            case (paddr[2])
                bpe_pkg::REG_POINT_COUNT: r_point_count <= pwdata[4:0];
                bpe_pkg::REG_DURATION:    r_duration    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bpe_pkg::REG_POINT_COUNT: prdata = {27'd0, r_point_count};
            bpe_pkg::REG_DURATION:    prdata = r_duration;
            default:                  prdata = '0;
        endcase
    end

    // Point count limited to between 2 and the table depth.
    always_comb begin
        if (32'(r_point_count) < 2) begin
            len_clamp = CW'(2);
        end else if (32'(r_point_count) > MAX_POINTS) begin
            len_clamp = CW'(MAX_POINTS);
        end else begin
            len_clamp = CW'(r_point_count);
        end
    end

    // Control point table, written by write items.
    assign pt_we = (r_state == bpe_pkg::S_IDLE) && start && (i_operation == bpe_pkg::OP_WRITE)
                   && (32'(i_point_index) < MAX_POINTS);

    bpe_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (AW'(i_point_index)),
        .i_wdata ({i_x_coord, i_y_coord, i_z_coord}),
        .i_raddr (raddr),
        .o_rdata (pt_rdata)
    );

    // Work table for the interpolation rounds.
    assign wk_wdata = {p_x, p_y, p_z};

    bpe_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (wk_we),
        .i_waddr (r_idx),
        .i_wdata (wk_wdata),
        .i_raddr (raddr),
        .o_rdata (wk_rdata)
    );

    // The first round reads the control points, later rounds the work table.
    assign rd_data = r_first ? pt_rdata : wk_rdata;

    bpe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_time  (i_time_value),
        .i_dur   (r_duration),
        .o_done  (div_done),
        .o_t     (t_val)
    );

    // Three coordinate lanes.
    bpe_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x (
        .i_clk (i_clk), .i_load (lerp_load), .i_a (r_a[95:64]),
        .i_b (rd_data[95:64]), .i_t (t_val), .o_p (p_x)
    );
    bpe_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y (
        .i_clk (i_clk), .i_load (lerp_load), .i_a (r_a[63:32]),
        .i_b (rd_data[63:32]), .i_t (t_val), .o_p (p_y)
    );
    bpe_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z (
        .i_clk (i_clk), .i_load (lerp_load), .i_a (r_a[31:0]),
        .i_b (rd_data[31:0]), .i_t (t_val), .o_p (p_z)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpe_pkg::S_IDLE;
            r_len   <= CW'(2);
            r_idx   <= '0;
            r_first <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_first <= n_first;
            r_valid <= done;
        end
    end

    // Sequencer next state and controls.
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_idx     = r_idx;
        n_first   = r_first;
        raddr     = '0;
        wk_we     = 1'b0;
        div_start = 1'b0;
        a_load    = 1'b0;
        lerp_load = 1'b0;
        done      = 1'b0;
        case (r_state)
            bpe_pkg::S_IDLE: begin
                if (start && (i_operation == bpe_pkg::OP_EVAL)) begin
                    div_start = 1'b1;
                    n_len     = len_clamp;
                    n_state   = bpe_pkg::S_DIV;
                end
            end
            bpe_pkg::S_DIV: begin
                if (div_done) begin
                    n_idx   = '0;
                    n_first = 1'b1;
                    n_state = bpe_pkg::S_RD0;
                end
            end
            bpe_pkg::S_RD0: begin
                raddr   = '0;
                n_state = bpe_pkg::S_LD0;
            end
            bpe_pkg::S_LD0: begin
                a_load  = 1'b1;
                n_state = bpe_pkg::S_RDB;
            end
            bpe_pkg::S_RDB: begin
                raddr   = AW'(r_idx + AW'(1));
                n_state = bpe_pkg::S_MUL;
            end
            bpe_pkg::S_MUL: begin
                lerp_load = 1'b1;
                n_state   = bpe_pkg::S_ACC;
            end
            bpe_pkg::S_ACC: begin
                wk_we = 1'b1;
                if ((CW'(r_idx) + CW'(1)) == (r_len - CW'(1))) begin
                    // Last step of a round: shrink the row.
                    n_len   = r_len - CW'(1);
                    n_first = 1'b0;
                    n_idx   = '0;
                    if (r_len == CW'(2)) begin
                        done    = 1'b1;
                        n_state = bpe_pkg::S_IDLE;
                    end else begin
                        n_state = bpe_pkg::S_RD0;
                    end
                end else begin
                    n_idx   = AW'(r_idx + AW'(1));
                    n_state = bpe_pkg::S_RDB;
                end
            end
            default: n_state = bpe_pkg::S_IDLE;
        endcase
    end

    // Left operand and fetched right operand of the current step, and the result.
    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a <= rd_data;
        end else if (wk_we) begin
            r_a <= r_b;
        end
        if (lerp_load) begin
            r_b <= rd_data;
        end
        if (done) begin
            r_pos_x <= p_x;
            r_pos_y <= p_y;
            r_pos_z <= p_z;
        end
    end

    assign busy           = (r_state != bpe_pkg::S_IDLE);
    assign o_result_valid = r_valid;
    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_pos_z        = r_pos_z;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the Bezier point evaluator.
`timescale 1ns / 1ps

module testbench;

    localparam int NPTS      = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 20;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_position;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               start = 1'b0;
    logic               busy;
    logic               i_operation = bpe_pkg::OP_WRITE;
    logic [3:0]         i_point_index = '0;
    logic signed [31:0] i_x_coord = '0;
    logic signed [31:0] i_y_coord = '0;
    logic signed [31:0] i_z_coord = '0;
    logic [31:0]        i_time_value = '0;
    logic               o_result_valid;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_pos_z;

    // Shadow copy of the control point table and registers.
    logic signed [31:0] ctrl_x [NPTS];
    logic signed [31:0] ctrl_y [NPTS];
    logic signed [31:0] ctrl_z [NPTS];
    logic [4:0]         cur_count = bpe_pkg::RST_POINT_COUNT;
    logic [31:0]        cur_duration = bpe_pkg::RST_DURATION;

    t_position          expected_positions [$];
    int                 fail_count = 0;
    int                 quiet_cycles = 0;
    bit                 no_gaps = 1'b0;

    bezier_point_evaluator dut (.*);

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One lerp step with floor scaling and 32-bit saturation.
    function automatic longint lerp_step(longint a, longint b, longint t);
        longint r;
        r = a + (((b - a) * t) >>> bpe_pkg::P_FRAC_BITS);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // Repeated interpolation of the first n points down to one.
    function automatic logic signed [31:0] casteljau(input logic signed [31:0] pts [NPTS],
                                                      int n, longint t);
        longint w [NPTS];
        for (int i = 0; i < n; i++) w[i] = pts[i];
        for (int len = n; len > 1; len--)
            for (int i = 0; i + 1 < len; i++) w[i] = lerp_step(w[i], w[i + 1], t);
        return w[0][31:0];
    endfunction

    // Curve parameter from time and duration, saturated.
    function automatic longint curve_param(logic [31:0] tv);
        logic [63:0] q;
        if (cur_duration == 0) return longint'(bpe_pkg::T_MAX);
        q = {16'h0, tv, 16'h0} / {32'h0, cur_duration};
        if (q > {33'h0, bpe_pkg::T_MAX}) return longint'(bpe_pkg::T_MAX);
        return longint'(q);
    endfunction

    // Update the shadow state for an accepted command.
    task automatic predict_command(logic op, logic [3:0] idx, logic signed [31:0] x,
                                   logic signed [31:0] y, logic signed [31:0] z,
                                   logic [31:0] tv);
        t_position p;
        longint    t;
        int        n;
        if (op == bpe_pkg::OP_WRITE) begin
            ctrl_x[idx] = x;
            ctrl_y[idx] = y;
            ctrl_z[idx] = z;
        end else begin
            t = curve_param(tv);
            n = cur_count;
            if (n < 2) n = 2;
            if (n > NPTS) n = NPTS;
            p.x = casteljau(ctrl_x, n, t);
            p.y = casteljau(ctrl_y, n, t);
            p.z = casteljau(ctrl_z, n, t);
            expected_positions = {expected_positions, p};
        end
    endtask

    // Send one command and wait for its transfer. Entered and left at a rising edge.
    task automatic send_command(logic op, logic [3:0] idx, logic signed [31:0] x,
                                logic signed [31:0] y, logic signed [31:0] z,
                                logic [31:0] tv);
        start         <= 1'b1;
        i_operation   <= op;
        i_point_index <= idx;
        i_x_coord     <= x;
        i_y_coord     <= y;
        i_z_coord     <= z;
        i_time_value  <= tv;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_command(op, idx, x, y, z, tv);
    endtask

    // Random pause on the command side, mostly short.
    task automatic sender_gap();
        int g;
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 50) return;
        g = (r < 92) ? $urandom_range(1, 3) : $urandom_range(20, 200);
        start <= 1'b0;
        repeat (g) @(posedge i_clk);
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (busy || expected_positions.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_register(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == bpe_pkg::REG_POINT_COUNT) cur_count = value[4:0];
        else cur_duration = value;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    // Time mostly inside the curve, sometimes beyond it or anywhere.
    function automatic logic [31:0] rand_time();
        logic [63:0] v;
        if ($urandom_range(9) == 0) return $urandom;
        v = ({32'h0, cur_duration} * $urandom_range(0, 98304)) >> 16;
        return (v > 64'hffff_ffff) ? 32'hffff_ffff : v[31:0];
    endfunction

    task automatic send_random_write(logic [3:0] idx);
        send_command(bpe_pkg::OP_WRITE, idx, rand_coord(), rand_coord(), rand_coord(), '0);
        sender_gap();
    endtask

    task automatic send_random_eval();
        send_command(bpe_pkg::OP_EVAL, 4'($urandom_range(15)), rand_coord(), rand_coord(),
                     rand_coord(), rand_time());
        sender_gap();
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_position e;
        if (i_rst_n && o_result_valid) begin
            if (expected_positions.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d", o_pos_x, o_pos_y, o_pos_z);
                fail_count++;
            end else begin
                e = expected_positions.pop_front();
                if (o_pos_x !== e.x) begin
                    $error("pos_x expected %0d actual %0d", e.x, o_pos_x);
                    fail_count++;
                end
                if (o_pos_y !== e.y) begin
                    $error("pos_y expected %0d actual %0d", e.y, o_pos_y);
                    fail_count++;
                end
                if (o_pos_z !== e.z) begin
                    $error("pos_z expected %0d actual %0d", e.z, o_pos_z);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset values, with a full table written first.
    task automatic test_reset_defaults();
        for (int i = 0; i < NPTS; i++)
            send_command(bpe_pkg::OP_WRITE, 4'(i),
                         (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000,
                         i * 32'sh0001_0000, -i * 32'sh0000_8000, '0);
        send_command(bpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'h0000_8000);
        send_command(bpe_pkg::OP_EVAL, 4'd15, '0, '0, '0, 32'hffff_ffff);
        drain();
    endtask

    // Extremes of time and duration, with the full point count.
    task automatic test_extremes();
        write_register(bpe_pkg::REG_POINT_COUNT, 32'd16);
        write_register(bpe_pkg::REG_DURATION, 32'hffff_ffff);
        send_command(bpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'h0);
        send_command(bpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'hffff_ffff);
        drain();
        write_register(bpe_pkg::REG_DURATION, 32'd0);
        send_command(bpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'h1234_5678);
        drain();
        write_register(bpe_pkg::REG_DURATION, 32'd1);
        send_command(bpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'd1);
        drain();
    endtask

    // Point counts below two and beyond the table.
    task automatic test_count_limits();
        write_register(bpe_pkg::REG_DURATION, bpe_pkg::RST_DURATION);
        write_register(bpe_pkg::REG_POINT_COUNT, 32'd0);
        send_command(bpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'h0001_8000);
        drain();
        write_register(bpe_pkg::REG_POINT_COUNT, 32'd1);
        send_command(bpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'h0000_4000);
        drain();
        write_register(bpe_pkg::REG_POINT_COUNT, 32'd31);
        send_command(bpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'h0000_c000);
        drain();
    endtask

    // Random phases, each with its own setting.
    task automatic test_random_phases();
        int count;
        int r;
        for (int ph = 0; ph < 26; ph++) begin
            r = $urandom_range(99);
            if (r < 70) count = $urandom_range(2, 6);
            else if (r < 85) count = $urandom_range(7, 16);
            else count = $urandom_range(0, 31);
            write_register(bpe_pkg::REG_POINT_COUNT, 32'(count));
            case ($urandom_range(6))
                0: write_register(bpe_pkg::REG_DURATION, 32'd1);
                1: write_register(bpe_pkg::REG_DURATION, 32'hffff_ffff);
                2: write_register(bpe_pkg::REG_DURATION, 32'd0);
                3: write_register(bpe_pkg::REG_DURATION, $urandom);
                default: write_register(bpe_pkg::REG_DURATION,
                                        $urandom_range(32'h100, 32'h0100_0000));
            endcase
            no_gaps = (ph % 5 == 4);
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(4) == 0) send_random_write(4'($urandom_range(15)));
                else send_random_eval();
            end
            drain();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extremes();
        test_count_limits();
        test_random_phases();
        drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
